FILE: sv/current_step_stimulus_sequencer_top_macros.svh
// Assertion macros for the current-step stimulus sequencer checker.
`ifndef CURRENT_STEP_STIMULUS_SEQUENCER_TOP_MACROS_SVH
`define CURRENT_STEP_STIMULUS_SEQUENCER_TOP_MACROS_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define CSSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cssq assertion failed");

// Non-overlapping implication: the consequent must hold in the cycle after the antecedent.
`define CSSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cssq assertion failed");

`endif

FILE: sv/cssq_pkg.sv
// Package of shared types, widths and reset values for the stimulus sequencer.
`timescale 1ns / 1ps
package cssq_pkg;

	localparam int TIME_WIDTH_DEF  = 24;
	localparam int LEVEL_WIDTH_DEF = 16;
	localparam int INC_W           = 15;
	localparam int REP_W           = 16;
	localparam int OUT_W           = 18;
	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 5;

	localparam int unsigned RST_PULSE = 2500;
	localparam int unsigned RST_DELAY = 0;
	localparam int unsigned RST_DOWN  = 0;
	localparam int          RST_START = -100;
	localparam int          RST_END   = 380;
	localparam int unsigned RST_INC   = 20;
	localparam int unsigned RST_REPS  = 1;
	localparam int          RST_OFFS  = 0;

	typedef enum logic [2:0] {
		REG_PULSE  = 3'd0,
		REG_DELAY  = 3'd1,
		REG_DOWN   = 3'd2,
		REG_START  = 3'd3,
		REG_END    = 3'd4,
		REG_INC    = 3'd5,
		REG_REPS   = 3'd6,
		REG_OFFSET = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] level;
		logic                    finished;
	} result_t;

endpackage

FILE: sv/cssq_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module cssq_regs #(
	parameter int TIME_WIDTH  = 24,
	parameter int LEVEL_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cssq_pkg::ADDR_W-1:0]   paddr,
	input  logic [cssq_pkg::DATA_W-1:0]   pwdata,
	output logic [cssq_pkg::DATA_W-1:0]   prdata,
	output logic [TIME_WIDTH-1:0]         pulse_ticks,
	output logic [TIME_WIDTH-1:0]         delay_ticks,
	output logic [TIME_WIDTH-1:0]         down_ticks,
	output logic [LEVEL_WIDTH-1:0]        start_level,
	output logic [LEVEL_WIDTH-1:0]        end_level,
	output logic [cssq_pkg::INC_W-1:0]    increment,
	output logic [cssq_pkg::REP_W-1:0]    repetitions,
	output logic [LEVEL_WIDTH-1:0]        offset_level
);
	import cssq_pkg::*;

	logic     wr_en;
	reg_idx_t idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks  <= TIME_WIDTH'(RST_PULSE);
			delay_ticks  <= TIME_WIDTH'(RST_DELAY);
			down_ticks   <= TIME_WIDTH'(RST_DOWN);
			start_level  <= LEVEL_WIDTH'(RST_START);
			end_level    <= LEVEL_WIDTH'(RST_END);
			increment    <= INC_W'(RST_INC);
			repetitions  <= REP_W'(RST_REPS);
			offset_level <= LEVEL_WIDTH'(RST_OFFS);
		end else if (wr_en) begin
			unique case (idx)
				REG_PULSE:  pulse_ticks  <= pwdata[TIME_WIDTH-1:0];
				REG_DELAY:  delay_ticks  <= pwdata[TIME_WIDTH-1:0];
				REG_DOWN:   down_ticks   <= pwdata[TIME_WIDTH-1:0];
				REG_START:  start_level  <= pwdata[LEVEL_WIDTH-1:0];
				REG_END:    end_level    <= pwdata[LEVEL_WIDTH-1:0];
				REG_INC:    increment    <= pwdata[INC_W-1:0];
				REG_REPS:   repetitions  <= pwdata[REP_W-1:0];
				REG_OFFSET: offset_level <= pwdata[LEVEL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PULSE:  prdata = DATA_W'(pulse_ticks);
			REG_DELAY:  prdata = DATA_W'(delay_ticks);
			REG_DOWN:   prdata = DATA_W'(down_ticks);
			REG_START:  prdata = DATA_W'(start_level);
			REG_END:    prdata = DATA_W'(end_level);
			REG_INC:    prdata = DATA_W'(increment);
			REG_REPS:   prdata = DATA_W'(repetitions);
			REG_OFFSET: prdata = DATA_W'(offset_level);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: sv/cssq_core.sv
// Sequencer state (age, step level, repetition count) and the output level logic.
`timescale 1ns / 1ps
module cssq_core #(
	parameter int TIME_WIDTH  = 24,
	parameter int LEVEL_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [TIME_WIDTH-1:0]      pulse_ticks,
	input  logic [TIME_WIDTH-1:0]      delay_ticks,
	input  logic [TIME_WIDTH-1:0]      down_ticks,
	input  logic [LEVEL_WIDTH-1:0]     start_level,
	input  logic [LEVEL_WIDTH-1:0]     end_level,
	input  logic [cssq_pkg::INC_W-1:0] increment,
	input  logic [cssq_pkg::REP_W-1:0] repetitions,
	input  logic [LEVEL_WIDTH-1:0]     offset_level,
	output cssq_pkg::result_t          result
);
	import cssq_pkg::*;

	// The step level stays below end_level plus twice the increment.
	localparam int STEP_W = (LEVEL_WIDTH > 16) ? LEVEL_WIDTH : 17;
	localparam int WIDE   = STEP_W + 2;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	logic [TIME_WIDTH-1:0] age_q;
	logic [STEP_W-1:0]     step_q;
	logic [REP_W-1:0]      rep_q;

	logic                   done;
	logic                   timing;
	logic [TIME_WIDTH:0]    pulse_start;
	logic [TIME_WIDTH:0]    lim_sum;
	logic [TIME_WIDTH-1:0]  limit;
	logic [TIME_WIDTH-1:0]  age_inc;
	logic                   cycle_end;
	logic [STEP_W-1:0]      step_mid;
	logic                   rep_hit;
	logic signed [WIDE-1:0] end_w;
	logic signed [WIDE-1:0] inc_w;
	logic signed [WIDE-1:0] step_w;
	logic signed [WIDE-1:0] mid_w;
	logic signed [WIDE-1:0] off_w;
	logic signed [WIDE-1:0] start_w;
	logic signed [WIDE-1:0] pulse_w;

	assign end_w   = WIDE'($signed(end_level));
	assign off_w   = WIDE'($signed(offset_level));
	assign start_w = WIDE'($signed(start_level));
	assign inc_w   = $signed(WIDE'(increment));
	assign step_w  = $signed(WIDE'(step_q));
	assign pulse_w = off_w + start_w + step_w;

	assign done   = rep_q >= repetitions;
	assign timing = step_w < (end_w + inc_w);

	assign pulse_start = (TIME_WIDTH + 1)'(down_ticks) + (TIME_WIDTH + 1)'(delay_ticks);
	assign lim_sum     = (TIME_WIDTH + 1)'(down_ticks) + (TIME_WIDTH + 1)'(pulse_ticks);
	// A cycle longer than the counter can count ends when the counter is full.
	assign limit     = lim_sum[TIME_WIDTH] ? TIME_MAX : lim_sum[TIME_WIDTH-1:0];
	assign age_inc   = (age_q == TIME_MAX) ? TIME_MAX : age_q + TIME_WIDTH'(1);
	assign cycle_end = age_inc >= limit;

	assign step_mid = (timing && cycle_end) ? step_q + STEP_W'(increment) : step_q;
	assign mid_w    = $signed(WIDE'(step_mid));
	assign rep_hit  = mid_w > end_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q  <= '0;
			step_q <= '0;
			rep_q  <= '0;
		end else if (adv && !done) begin
			if (timing) begin
				age_q <= cycle_end ? '0 : age_inc;
			end
			if (rep_hit) begin
				rep_q  <= rep_q + REP_W'(1);
				step_q <= '0;
			end else begin
				step_q <= step_mid;
			end
		end
	end

	always_comb begin
		result.level    = off_w[OUT_W-1:0];
		result.finished = done;
		if (!done && timing) begin
			if (age_q < down_ticks) begin
				result.level = '0;
			end else if ((TIME_WIDTH + 1)'(age_q) >= pulse_start) begin
				result.level = pulse_w[OUT_W-1:0];
			end
		end
	end

endmodule

FILE: sv/current_step_stimulus_sequencer_top.sv
// Top level of the current-step stimulus sequencer: handshake stages and register port.
// A tick word is registered in the input stage, then its result word in the output register.
// Throughput: one word per cycle while the output is not stalled; the input stage feeds the output register directly.
// The state update for a tick happens as it moves from the input stage to the output.
// Reset clears the sequencer state and loads the register defaults at once.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module current_step_stimulus_sequencer_top #(
	parameter int TIME_WIDTH  = cssq_pkg::TIME_WIDTH_DEF,
	parameter int LEVEL_WIDTH = cssq_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               tick,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [cssq_pkg::OUT_W-1:0]  drive_level,
	output logic                               finished,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cssq_pkg::ADDR_W-1:0]        paddr,
	input  logic [cssq_pkg::DATA_W-1:0]        pwdata,
	output logic [cssq_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import cssq_pkg::*;

	logic                   valid_s1;
	logic                   tick_s1;
	logic                   out_valid_q;
	result_t                result_q;
	result_t                result;
	logic                   accept;
	logic                   move;
	logic [TIME_WIDTH-1:0]  pulse_ticks;
	logic [TIME_WIDTH-1:0]  delay_ticks;
	logic [TIME_WIDTH-1:0]  down_ticks;
	logic [LEVEL_WIDTH-1:0] start_level;
	logic [LEVEL_WIDTH-1:0] end_level;
	logic [INC_W-1:0]       increment;
	logic [REP_W-1:0]       repetitions;
	logic [LEVEL_WIDTH-1:0] offset_level;

	assign pready = 1'b1;

	// The input stage drains whenever the output register is empty or being taken.
	assign move     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
		if (move) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = result_q.level;
	assign finished    = result_q.finished;

	cssq_regs #(
		.TIME_WIDTH  (TIME_WIDTH),
		.LEVEL_WIDTH (LEVEL_WIDTH)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pulse_ticks  (pulse_ticks),
		.delay_ticks  (delay_ticks),
		.down_ticks   (down_ticks),
		.start_level  (start_level),
		.end_level    (end_level),
		.increment    (increment),
		.repetitions  (repetitions),
		.offset_level (offset_level)
	);

	cssq_core #(
		.TIME_WIDTH  (TIME_WIDTH),
		.LEVEL_WIDTH (LEVEL_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (move && tick_s1),
		.pulse_ticks  (pulse_ticks),
		.delay_ticks  (delay_ticks),
		.down_ticks   (down_ticks),
		.start_level  (start_level),
		.end_level    (end_level),
		.increment    (increment),
		.repetitions  (repetitions),
		.offset_level (offset_level),
		.result       (result)
	);

endmodule

FILE: sv/cssq_checker.sv
// Port-level checker for the stimulus sequencer and its bind to the top level.
`timescale 1ns / 1ps
`include "current_step_stimulus_sequencer_top_macros.svh"
module cssq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [17:0] drive_level,
	input logic        finished,
	input logic        pready
);

	// A stalled result word holds.
	`CSSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(drive_level) && $stable(finished))

	// The input side only stalls while a finished word waits downstream.
	`CSSQ_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A new result after an empty output slot comes from a word accepted into the input stage and then moved on.
	`CSSQ_ASSERT_NOW(a_result_origin, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

	// The register port never inserts wait states.
	`CSSQ_ASSERT_NOW(a_pready_high, clk, arst_n, 1'b1, pready)

endmodule

bind current_step_stimulus_sequencer_top cssq_checker u_cssq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.drive_level (drive_level),
	.finished    (finished),
	.pready      (pready)
);
